FILE: design/srpdp_pkg.sv
// Shared types and constants of the shelf row partition DP unit.
// Holds the beat structs, status codes and the cell control bundle.
// No dependencies.
package srpdp_pkg;

	localparam int MIN_BLOCKS = 5;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_SIZE  = 2'd1,
		ST_BAD_COUNT = 2'd2
	} status_t;

	typedef struct packed {
		logic [15:0] block_width;
		logic [15:0] block_height;
		logic        last_block;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  row_index;
		logic [6:0]  row_blocks;
		logic [6:0]  row_count;
		logic [21:0] total_height;
		logic        last_row;
	} out_beat_t;

	typedef enum logic [2:0] {
		CELL_HOLD = 3'd0,
		CELL_ROT  = 3'd1,
		CELL_UPD  = 3'd2,
		CELL_LOAD = 3'd3,
		CELL_CLR  = 3'd4
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t  mode;
		logic [15:0] blk_w;
		logic [15:0] blk_h;
		logic [15:0] shelf;
	} cell_ctl_t;

endpackage

FILE: design/srpdp_cell.sv
// One DP entry of the row: last-row height, last-row length, best total.
// Rotates toward its lower neighbor for scans, extends its lower neighbor's entry on update.
// Depends on srpdp_pkg.
module srpdp_cell #(
	parameter int TW = 23
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srpdp_pkg::cell_ctl_t ctl,
	input  logic                 dn_valid,
	input  logic [15:0]          dn_height,
	input  logic [15:0]          dn_length,
	input  logic [TW-1:0]        dn_total,
	input  logic                 up_valid,
	input  logic [15:0]          up_height,
	input  logic [15:0]          up_length,
	input  logic [TW-1:0]        up_total,
	output logic                 valid,
	output logic [15:0]          height,
	output logic [15:0]          length,
	output logic [TW-1:0]        total
);

	logic          valid_q;
	logic [15:0]   height_q;
	logic [15:0]   length_q;
	logic [TW-1:0] total_q;

	logic [16:0]   ext_len;
	logic          fits;
	logic [15:0]   ext_h;
	logic [TW-1:0] ext_tot;

	assign ext_len = {1'b0, dn_length} + {1'b0, ctl.blk_w};
	assign fits    = dn_valid && (ext_len <= {1'b0, ctl.shelf});
	assign ext_h   = (dn_height > ctl.blk_h) ? dn_height : ctl.blk_h;
	assign ext_tot = dn_total + TW'(ext_h - dn_height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctl.mode)
				srpdp_pkg::CELL_HOLD: valid_q <= valid_q;
				srpdp_pkg::CELL_ROT:  valid_q <= up_valid;
				srpdp_pkg::CELL_UPD:  valid_q <= fits;
				srpdp_pkg::CELL_LOAD: valid_q <= dn_valid;
				srpdp_pkg::CELL_CLR:  valid_q <= 1'b0;
				default:              valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.mode)
			srpdp_pkg::CELL_ROT: begin
				height_q <= up_height;
				length_q <= up_length;
				total_q  <= up_total;
			end
			srpdp_pkg::CELL_UPD: begin
				height_q <= ext_h;
				length_q <= ext_len[15:0];
				total_q  <= ext_tot;
			end
			srpdp_pkg::CELL_LOAD: begin
				height_q <= dn_height;
				length_q <= dn_length;
				total_q  <= dn_total;
			end
			default: begin
				height_q <= height_q;
				length_q <= length_q;
				total_q  <= total_q;
			end
		endcase
	end

	assign valid  = valid_q;
	assign height = height_q;
	assign length = length_q;
	assign total  = total_q;

endmodule

FILE: design/shelf_row_partition_dp_unit.sv
// Top level of the shelf row partition DP unit: control, cell row, backtrack memories.
// Depends on srpdp_pkg and srpdp_cell.
//
// Usage: configure shelf_width through cfg_wr_en/cfg_wr_data while idle. Send blocks on
// the in channel (valid/ready), in order; last_block marks the final block of a set.
// Blocks that are not last produce no beat. On the last block one beat per row comes out
// on the out channel, first row first, the final one with last_row set; a bad set gives a
// single beat carrying the status code.
// Sequence: a block that updates the DP is accepted, then the cell ring rotates once in
// full for the new-row minimum, then the row shifts once; the first block and blocks
// skipped because of an error end with the accept. After the last block the ring
// rotates once more for the final minimum, backtracking walks the blocks from last to
// first, and each row beat is a stack read, then a load of the output register.
// Reset clears the DP row valid bits, the block count and the error flag and sets
// shelf_width to 65535. A stalled receiver holds the output register; the unit waits
// with the next row until the register is free, and returns to accepting blocks as soon
// as the final beat is registered.
module shelf_row_partition_dp_unit #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [15:0]          cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  srpdp_pkg::in_beat_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output srpdp_pkg::out_beat_t out_data
);

	localparam int TW = 16 + $clog2(MAX_BLOCKS + 1);
	localparam int IW = $clog2(MAX_BLOCKS + 1);
	localparam int CW = $clog2(MAX_BLOCKS + 2);
	localparam int SW = $clog2(MAX_BLOCKS);
	localparam int AW = $clog2(MAX_BLOCKS);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SCAN   = 9'b000000010,
		S_UPD    = 9'b000000100,
		S_FSCAN  = 9'b000001000,
		S_BT_PRE = 9'b000010000,
		S_BT     = 9'b000100000,
		S_OUT_RD = 9'b001000000,
		S_OUT_LD = 9'b010000000,
		S_ERR_LD = 9'b100000000
	} state_t;

	state_t            state_q;
	logic [15:0]       shelf_q;
	logic [CW-1:0]     blk_cnt_q;
	logic              err_q;
	logic [15:0]       bw_q;
	logic [15:0]       bh_q;
	logic              last_q;
	srpdp_pkg::status_t code_q;

	logic [SW-1:0]     scan_q;
	logic              have_q;
	logic [TW-1:0]     best_tot_q;
	logic [IW-1:0]     best_idx_q;

	logic [IW-1:0]     i_q;
	logic [IW-1:0]     cur_q;
	logic [IW-1:0]     cnt_q;
	logic [IW-1:0]     rows_q;
	logic [IW-1:0]     k_q;

	logic [IW-1:0]     src_mem [0:MAX_BLOCKS];
	logic [IW-1:0]     src_rd_q;
	logic [IW-1:0]     stk_mem [0:MAX_BLOCKS-1];
	logic [IW-1:0]     stk_rd_q;

	logic                 out_valid_q;
	srpdp_pkg::out_beat_t out_q;

	logic                 accept;
	logic [CW-1:0]        cnt_nx;
	logic                 bad;
	logic                 err_nx;
	logic                 do_dp;
	srpdp_pkg::status_t   code_nx;
	logic                 slot_free;
	logic                 scan_end;
	logic                 bt_end;
	logic                 clr_run;
	logic [IW-1:0]        src_raddr;
	logic [AW-1:0]        stk_raddr;

	srpdp_pkg::cell_mode_t mode0;
	srpdp_pkg::cell_mode_t moden;
	logic                  seed_valid;
	logic [15:0]           seed_height;
	logic [15:0]           seed_length;
	logic [TW-1:0]         seed_total;

	logic                  c_valid  [0:MAX_BLOCKS-1];
	logic [15:0]           c_height [0:MAX_BLOCKS-1];
	logic [15:0]           c_length [0:MAX_BLOCKS-1];
	logic [TW-1:0]         c_total  [0:MAX_BLOCKS-1];

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign slot_free = !out_valid_q || out_ready;
	assign scan_end  = (scan_q == SW'(MAX_BLOCKS - 1));
	assign bt_end    = (state_q == S_BT) && (i_q == IW'(1));
	assign clr_run   = bt_end || ((state_q == S_ERR_LD) && slot_free);

	always_comb begin
		cnt_nx = (blk_cnt_q <= CW'(MAX_BLOCKS)) ? blk_cnt_q + CW'(1) : blk_cnt_q;
		bad    = (in_data.block_width == 16'd0) || (in_data.block_height == 16'd0) ||
			(in_data.block_width > shelf_q);
		err_nx = err_q || bad;
		do_dp  = (cnt_nx <= CW'(MAX_BLOCKS)) && !err_nx;
		if ((cnt_nx < CW'(srpdp_pkg::MIN_BLOCKS)) || (cnt_nx > CW'(MAX_BLOCKS))) begin
			code_nx = srpdp_pkg::ST_BAD_COUNT;
		end else if (err_nx) begin
			code_nx = srpdp_pkg::ST_BAD_SIZE;
		end else begin
			code_nx = srpdp_pkg::ST_OK;
		end
	end

	// cell row control
	always_comb begin
		mode0       = srpdp_pkg::CELL_HOLD;
		moden       = srpdp_pkg::CELL_HOLD;
		seed_valid  = have_q;
		seed_height = bh_q;
		seed_length = bw_q;
		seed_total  = best_tot_q + TW'(bh_q);
		if (clr_run) begin
			mode0 = srpdp_pkg::CELL_CLR;
			moden = srpdp_pkg::CELL_CLR;
		end else if (state_q == S_SCAN || state_q == S_FSCAN) begin
			mode0 = srpdp_pkg::CELL_ROT;
			moden = srpdp_pkg::CELL_ROT;
		end else if (state_q == S_UPD) begin
			mode0 = srpdp_pkg::CELL_LOAD;
			moden = srpdp_pkg::CELL_UPD;
		end else if (accept && do_dp && cnt_nx == CW'(1)) begin
			mode0       = srpdp_pkg::CELL_LOAD;
			seed_valid  = 1'b1;
			seed_height = in_data.block_height;
			seed_length = in_data.block_width;
			seed_total  = TW'(in_data.block_height);
		end
	end

	for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
		srpdp_pkg::cell_ctl_t ctl;
		logic                 dv;
		logic [15:0]          dh;
		logic [15:0]          dl;
		logic [TW-1:0]        dt;
		localparam int UP = (g == MAX_BLOCKS - 1) ? 0 : g + 1;

		assign ctl.mode  = (g == 0) ? mode0 : moden;
		assign ctl.blk_w = bw_q;
		assign ctl.blk_h = bh_q;
		assign ctl.shelf = shelf_q;

		if (g == 0) begin : g_seed
			assign dv = seed_valid;
			assign dh = seed_height;
			assign dl = seed_length;
			assign dt = seed_total;
		end else begin : g_prev
			assign dv = c_valid[g-1];
			assign dh = c_height[g-1];
			assign dl = c_length[g-1];
			assign dt = c_total[g-1];
		end

		srpdp_cell #(.TW(TW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.dn_valid  (dv),
			.dn_height (dh),
			.dn_length (dl),
			.dn_total  (dt),
			.up_valid  (c_valid[UP]),
			.up_height (c_height[UP]),
			.up_length (c_length[UP]),
			.up_total  (c_total[UP]),
			.valid     (c_valid[g]),
			.height    (c_height[g]),
			.length    (c_length[g]),
			.total     (c_total[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shelf_q <= 16'hFFFF;
		end else if (cfg_wr_en) begin
			shelf_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			blk_cnt_q <= '0;
			err_q     <= 1'b0;
			scan_q    <= '0;
			have_q    <= 1'b0;
			i_q       <= '0;
			k_q       <= '0;
			rows_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						blk_cnt_q <= cnt_nx;
						err_q     <= err_nx;
						scan_q    <= '0;
						have_q    <= 1'b0;
						if (do_dp && cnt_nx != CW'(1)) begin
							state_q <= S_SCAN;
						end else if (in_data.last_block) begin
							state_q <= S_ERR_LD;
						end
					end
				end
				S_SCAN, S_FSCAN: begin
					if (c_valid[0] && (!have_q || c_total[0] < best_tot_q)) begin
						have_q <= 1'b1;
					end
					scan_q <= scan_q + SW'(1);
					if (scan_end) begin
						scan_q  <= '0;
						state_q <= (state_q == S_SCAN) ? S_UPD : S_BT_PRE;
					end
				end
				S_UPD: begin
					have_q <= 1'b0;
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (code_q != srpdp_pkg::ST_OK) begin
						state_q <= S_ERR_LD;
					end else begin
						state_q <= S_FSCAN;
					end
				end
				S_BT_PRE: begin
					i_q     <= IW'(blk_cnt_q);
					rows_q  <= '0;
					state_q <= S_BT;
				end
				S_BT: begin
					if (cur_q <= IW'(1)) begin
						rows_q <= rows_q + IW'(1);
					end
					i_q <= i_q - IW'(1);
					if (bt_end) begin
						k_q       <= '0;
						blk_cnt_q <= '0;
						err_q     <= 1'b0;
						state_q   <= S_OUT_RD;
					end
				end
				S_OUT_RD: begin
					state_q <= S_OUT_LD;
				end
				S_OUT_LD: begin
					if (slot_free) begin
						k_q     <= k_q + IW'(1);
						state_q <= (k_q + IW'(1) == rows_q) ? S_IDLE : S_OUT_RD;
					end
				end
				S_ERR_LD: begin
					if (slot_free) begin
						blk_cnt_q <= '0;
						err_q     <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bw_q   <= in_data.block_width;
			bh_q   <= in_data.block_height;
			last_q <= in_data.last_block;
			code_q <= code_nx;
		end
		if ((state_q == S_SCAN || state_q == S_FSCAN) && c_valid[0] &&
			(!have_q || c_total[0] < best_tot_q)) begin
			best_tot_q <= c_total[0];
			best_idx_q <= IW'(scan_q) + IW'(1);
		end
		if (state_q == S_BT_PRE) begin
			cur_q <= best_idx_q;
			cnt_q <= '0;
		end else if (state_q == S_BT) begin
			if (cur_q <= IW'(1)) begin
				cnt_q <= '0;
				cur_q <= (src_rd_q > IW'(MAX_BLOCKS)) ? IW'(1) : src_rd_q;
			end else begin
				cnt_q <= cnt_q + IW'(1);
				cur_q <= cur_q - IW'(1);
			end
		end
	end

	// new-row source per block, read back while walking the blocks from last to first
	assign src_raddr = (state_q == S_BT_PRE) ? IW'(blk_cnt_q) : i_q - IW'(1);

	always_ff @(posedge clk) begin
		if (state_q == S_UPD && have_q) begin
			src_mem[IW'(blk_cnt_q)] <= best_idx_q;
		end
		src_rd_q <= src_mem[src_raddr];
	end

	// row sizes, pushed last row first, popped first row first
	assign stk_raddr = AW'(rows_q - IW'(1) - k_q);

	always_ff @(posedge clk) begin
		if (state_q == S_BT && cur_q <= IW'(1)) begin
			stk_mem[AW'(rows_q)] <= cnt_q + IW'(1);
		end
		stk_rd_q <= stk_mem[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT_LD || state_q == S_ERR_LD) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT_LD && slot_free) begin
			out_q.status       <= srpdp_pkg::ST_OK;
			out_q.row_index    <= 6'(k_q);
			out_q.row_blocks   <= 7'(stk_rd_q);
			out_q.row_count    <= 7'(rows_q);
			out_q.total_height <= 22'(best_tot_q);
			out_q.last_row     <= (k_q + IW'(1) == rows_q);
		end else if (state_q == S_ERR_LD && slot_free) begin
			out_q.status       <= code_q;
			out_q.row_index    <= '0;
			out_q.row_blocks   <= '0;
			out_q.row_count    <= '0;
			out_q.total_height <= '0;
			out_q.last_row     <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
